>>> src/vgac_pkg.sv
// ----------------------------------------------------------------------------
// vgac_pkg - shared types and constants
// Item payloads, operation / phase / status codes and register indexes for
// the voice-activity-gated audio capture block.
// ----------------------------------------------------------------------------
package vgac_pkg;

  localparam int OP_W         = 2;
  localparam int SAMPLE_W     = 16;
  localparam int READ_INDEX_W = 17;
  localparam int STATUS_W     = 2;
  localparam int PHASE_W      = 2;
  localparam int COUNT_W      = 18;
  localparam int MAX_CAP_W    = 18;
  localparam int SIL_W        = 21;
  localparam int CFG_DATA_W   = 21;
  localparam int CFG_INDEX_W  = 1;

  localparam logic [MAX_CAP_W-1:0] MAX_CAP_RESET   = 18'd131072;
  localparam logic [SIL_W-1:0]     SIL_LIMIT_RESET = 21'd16000;
  localparam logic [SIL_W-1:0]     SIL_MAX         = {SIL_W{1'b1}};

  typedef enum logic [OP_W-1:0] {
    OP_START  = 2'd0,
    OP_SAMPLE = 2'd1,
    OP_VAD    = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_REC  = 2'd2,
    PH_DONE = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 2'd0,
    STS_NOT_DONE = 2'd1,
    STS_RANGE    = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_MAX_CAPTURE   = 1'b0,
    CFG_SILENCE_LIMIT = 1'b1
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [1:0] {
    FS_IDLE,
    FS_READ,
    FS_COPY
  } fsm_t;

  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic signed [SAMPLE_W-1:0] sample_value;
    logic                     chunk_first;
    logic                     vad_speech;
    logic [READ_INDEX_W-1:0]  read_index;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic [PHASE_W-1:0]         phase;
    logic [COUNT_W-1:0]         captured_count;
    logic signed [SAMPLE_W-1:0] read_sample;
  } rsp_t;

endpackage

>>> src/vgac_if.sv
// ----------------------------------------------------------------------------
// vgac_if - item channels
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface vgac_req_if;
  logic              valid;
  logic              ready;
  vgac_pkg::req_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vgac_rsp_if;
  logic              valid;
  logic              ready;
  vgac_pkg::rsp_t    data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> src/vgac_ram.sv
// ----------------------------------------------------------------------------
// vgac_ram - single-port synchronous RAM
// One read or write per cycle, read data registered (read-first).
// ----------------------------------------------------------------------------
module vgac_ram #(
  parameter int DEPTH = 2048,
  parameter int WIDTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/vad_gated_audio_capture.sv
// ----------------------------------------------------------------------------
// vad_gated_audio_capture - VAD-gated audio capture controller
// Keeps a pre-roll of the latest chunk while waiting for speech, copies it
// into the capture store at speech onset, records until the length or
// silence limit, then serves reads of the captured samples.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          carries
//  --------  ---  -----------------  -------------------------------------
//  req       in   valid/ready        operation, sample, chunk mark, VAD, index
//  rsp       out  valid/ready        status, phase, captured count, sample
//  cfg       in   cfg_we (no wait)   max_capture_samples, silence_limit
//
// Start, sample and VAD items and refused reads form their result in the cycle
// they are accepted; a read that returns a sample waits in FS_READ for the
// registered capture RAM read. A speech onset copies the pre-roll in FS_COPY
// at one sample a cycle, up to the capture limit. One item in flight; a skid
// register behind the output register lets an item in while a result waits.
// Synchronous reset; the sample stores are not cleared (only read below fill).
// ----------------------------------------------------------------------------
module vad_gated_audio_capture #(
  parameter int CAPTURE_DEPTH = 131072,
  parameter int PREROLL_DEPTH = 2048,
  parameter int SILENCE_STEP  = 512
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [vgac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [vgac_pkg::CFG_DATA_W-1:0]  cfg_data,
  vgac_req_if.sink                       req,
  vgac_rsp_if.source                     rsp
);

  import vgac_pkg::*;

  // widths that follow from the store depths
  localparam int CW  = $clog2(CAPTURE_DEPTH + 1);            // capture fill
  localparam int CAW = (CAPTURE_DEPTH > 1) ? $clog2(CAPTURE_DEPTH) : 1;
  localparam int PW  = $clog2(PREROLL_DEPTH + 1);            // pre-roll fill
  localparam int PAW = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
  localparam int MW  = (CW > MAX_CAP_W) ? CW : MAX_CAP_W;    // limit clamp
  localparam int XW  = (PW > CW) ? PW : CW;                  // copy length
  localparam int RW  = (CW > READ_INDEX_W) ? CW : READ_INDEX_W;

  // configuration
  logic [MAX_CAP_W-1:0] max_cap;
  logic [SIL_W-1:0]     sil_limit;

  // control state
  fsm_t            fsm, fsm_next;
  phase_t          phase, phase_next;
  logic [CW-1:0]   fill, fill_next;
  logic [SIL_W-1:0] sil, sil_next;
  logic [PW-1:0]   pfill, pfill_next;
  logic [PW-1:0]   copy_len, copy_len_next;
  logic [PW-1:0]   copy_cnt, copy_cnt_next;
  logic            copy_pend, copy_pend_next;

  // RAM ports
  logic                 cap_we, pre_we;
  logic [CAW-1:0]       cap_addr;
  logic [PAW-1:0]       pre_addr;
  logic [SAMPLE_W-1:0]  cap_wdata, cap_rdata, pre_rdata;

  // result path
  logic  res_fire;
  rsp_t  res;
  logic  out_valid, skid_valid;
  rsp_t  out_data, skid_data;

  // helpers
  logic [MW-1:0]    lim_wide;
  logic [CW-1:0]    lim;
  logic [PW-1:0]    pf_base;
  logic [SIL_W:0]   sil_sum;
  logic [SIL_W-1:0] sil_sat;
  logic             accept;

  vgac_ram #(.DEPTH(CAPTURE_DEPTH), .WIDTH(SAMPLE_W)) u_capture (
    .clk   (clk),
    .we    (cap_we),
    .addr  (cap_addr),
    .wdata (cap_wdata),
    .rdata (cap_rdata)
  );

  vgac_ram #(.DEPTH(PREROLL_DEPTH), .WIDTH(SAMPLE_W)) u_preroll (
    .clk   (clk),
    .we    (pre_we),
    .addr  (pre_addr),
    .wdata (req.data.sample_value),
    .rdata (pre_rdata)
  );

  // Configuration registers; the user must write them only while idle (not enforced here).
  always_ff @(posedge clk) begin
    if (rst) begin
      max_cap   <= MAX_CAP_RESET;
      sil_limit <= SIL_LIMIT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_CAPTURE:   max_cap   <= cfg_data[MAX_CAP_W-1:0];
        CFG_SILENCE_LIMIT: sil_limit <= cfg_data[SIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective capture limit: zero counts as one, clipped to the store size.
  always_comb begin
    if (max_cap == '0) begin
      lim_wide = MW'(1);
    end else if (MW'(max_cap) > MW'(CAPTURE_DEPTH)) begin
      lim_wide = MW'(CAPTURE_DEPTH);
    end else begin
      lim_wide = MW'(max_cap);
    end
    lim = CW'(lim_wide);
  end

  assign req.ready = (fsm == FS_IDLE) && !skid_valid;
  assign accept    = req.valid && req.ready;

  assign pf_base = req.data.chunk_first ? '0 : pfill;
  assign sil_sum = {1'b0, sil} + (SIL_W + 1)'(SILENCE_STEP);
  assign sil_sat = (sil_sum > {1'b0, SIL_MAX}) ? SIL_MAX : sil_sum[SIL_W-1:0];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= FS_IDLE;
      phase     <= PH_IDLE;
      fill      <= '0;
      sil       <= '0;
      pfill     <= '0;
      copy_pend <= 1'b0;
    end else begin
      fsm       <= fsm_next;
      phase     <= phase_next;
      fill      <= fill_next;
      sil       <= sil_next;
      pfill     <= pfill_next;
      copy_pend <= copy_pend_next;
    end
  end

  always_ff @(posedge clk) begin
    copy_len <= copy_len_next;
    copy_cnt <= copy_cnt_next;
  end

  // Sequencer: next state, RAM accesses and the result item
  always_comb begin
    fsm_next       = fsm;
    phase_next     = phase;
    fill_next      = fill;
    sil_next       = sil;
    pfill_next     = pfill;
    copy_len_next  = copy_len;
    copy_cnt_next  = copy_cnt;
    copy_pend_next = copy_pend;
    cap_we         = 1'b0;
    cap_addr       = CAW'(fill);
    cap_wdata      = req.data.sample_value;
    pre_we         = 1'b0;
    pre_addr       = PAW'(pf_base);
    res_fire       = 1'b0;
    res.status     = STS_OK;
    res.read_sample = '0;

    case (fsm)
      FS_IDLE: begin
        if (accept) begin
          case (req.data.operation)
            OP_START: begin
              phase_next = PH_WAIT;
              fill_next  = '0;
              sil_next   = '0;
              pfill_next = '0;
              res_fire   = 1'b1;
            end
            OP_SAMPLE: begin
              if (phase == PH_WAIT) begin
                // latest chunk only; overflow samples dropped
                pfill_next = pf_base;
                if (pf_base < PW'(PREROLL_DEPTH)) begin
                  pre_we     = 1'b1;
                  pfill_next = pf_base + PW'(1);
                end
              end else if (phase == PH_REC) begin
                if (fill >= lim) begin
                  phase_next = PH_DONE;
                end else begin
                  cap_we    = 1'b1;
                  fill_next = fill + CW'(1);
                  if (fill_next >= lim) begin
                    phase_next = PH_DONE;
                  end
                end
              end
              res_fire = 1'b1;
            end
            OP_VAD: begin
              if (phase == PH_WAIT) begin
                if (req.data.vad_speech) begin
                  // speech onset: copy pre-roll, clipped to the limit
                  phase_next     = PH_REC;
                  sil_next       = '0;
                  copy_len_next  = (XW'(pfill) > XW'(lim)) ? PW'(lim) : pfill;
                  copy_cnt_next  = '0;
                  copy_pend_next = 1'b0;
                  fsm_next       = FS_COPY;
                end else begin
                  res_fire = 1'b1;
                end
              end else begin
                if (phase == PH_REC) begin
                  if (req.data.vad_speech) begin
                    sil_next = '0;
                  end else begin
                    sil_next = sil_sat;
                    if (sil_sat >= sil_limit) begin
                      phase_next = PH_DONE;
                    end
                  end
                end
                res_fire = 1'b1;
              end
            end
            OP_READ: begin
              cap_addr = CAW'(req.data.read_index);
              if (phase != PH_DONE) begin
                res.status = STS_NOT_DONE;
                res_fire   = 1'b1;
              end else if (RW'(req.data.read_index) >= RW'(fill)) begin
                res.status = STS_RANGE;
                res_fire   = 1'b1;
              end else begin
                fsm_next = FS_READ;
              end
            end
            default: ;
          endcase
        end
      end

      FS_READ: begin
        res.read_sample = cap_rdata;
        res_fire        = 1'b1;
        fsm_next        = FS_IDLE;
      end

      FS_COPY: begin
        // read at copy_cnt, write the word read last cycle at the fill
        pre_addr = PAW'(copy_cnt);
        if (copy_pend) begin
          cap_we    = 1'b1;
          cap_wdata = pre_rdata;
          fill_next = fill + CW'(1);
        end
        if (copy_cnt != copy_len) begin
          copy_cnt_next  = copy_cnt + PW'(1);
          copy_pend_next = 1'b1;
        end else begin
          copy_pend_next = 1'b0;
          phase_next     = (fill_next >= lim) ? PH_DONE : PH_REC;
          res_fire       = 1'b1;
          fsm_next       = FS_IDLE;
        end
      end

      default: fsm_next = FS_IDLE;
    endcase

    res.phase          = phase_next;
    res.captured_count = COUNT_W'(fill_next);
  end

  // Output register with skid stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !rsp.ready) begin
      if (res_fire) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= res_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !rsp.ready) begin
      if (res_fire) begin
        skid_data <= res;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (res_fire) begin
      out_data <= res;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

endmodule

>>> sim/vgac_tb_pkg.sv
// ----------------------------------------------------------------------------
// vgac_tb_pkg - result predictor and scoreboard for the capture controller
// Tracks phase, fill counts, silence total and both sample stores, works out
// the expected result of every accepted item and checks the results in order.
// ----------------------------------------------------------------------------
package vgac_tb_pkg;
  import vgac_pkg::*;

  localparam int unsigned CAP_DEPTH     = 131072;
  localparam int unsigned PREROLL_DEPTH = 2048;
  localparam int unsigned SILENCE_STEP  = 512;
  localparam int unsigned SIL_CEIL      = SIL_MAX;

  class capture_checker;
    bit [SAMPLE_W-1:0]    capture_mem [CAP_DEPTH];
    bit [SAMPLE_W-1:0]    preroll_mem [PREROLL_DEPTH];
    phase_t               phase;
    int unsigned          fill;
    int unsigned          silence;
    int unsigned          preroll_len;
    logic [MAX_CAP_W-1:0] max_reg;
    logic [SIL_W-1:0]     sil_reg;
    rsp_t                 awaited [$];
    int unsigned          failures;
    int unsigned          checked;
    int unsigned          op_seen [4];
    int unsigned          reads_with_data;
    int unsigned          onsets;
    int unsigned          completions;

    function new();
      phase       = PH_IDLE;
      fill        = 0;
      silence     = 0;
      preroll_len = 0;
      max_reg     = MAX_CAP_RESET;
      sil_reg     = SIL_LIMIT_RESET;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        CFG_MAX_CAPTURE:   max_reg = value[MAX_CAP_W-1:0];
        CFG_SILENCE_LIMIT: sil_reg = value[SIL_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the store depth as the depth
    function int unsigned length_cap();
      int unsigned m;
      m = max_reg;
      if (m == 0) m = 1;
      if (m > CAP_DEPTH) m = CAP_DEPTH;
      return m;
    endfunction

    function void store_sample(bit [SAMPLE_W-1:0] v);
      int unsigned cap;
      cap = length_cap();
      if (fill >= cap) begin
        phase = PH_DONE;
        return;
      end
      capture_mem[fill] = v;
      fill++;
      if (fill >= cap) phase = PH_DONE;
    endfunction

    // returns 0 when the block merely drops the item
    function bit accept_request(req_t r);
      rsp_t        want;
      phase_t      was;
      bit          live;
      int unsigned i;
      want = '0;
      was  = phase;
      live = 1'b1;
      op_seen[r.operation]++;
      case (op_t'(r.operation))
        OP_START: begin
          phase       = PH_WAIT;
          fill        = 0;
          silence     = 0;
          preroll_len = 0;
        end
        OP_SAMPLE: begin
          if (phase == PH_WAIT) begin
            if (r.chunk_first) preroll_len = 0;
            if (preroll_len < PREROLL_DEPTH) begin
              preroll_mem[preroll_len] = r.sample_value;
              preroll_len++;
            end
          end else if (phase == PH_REC) begin
            store_sample(r.sample_value);
          end else begin
            live = 1'b0;
          end
        end
        OP_VAD: begin
          if (phase == PH_WAIT) begin
            if (r.vad_speech) begin
              phase   = PH_REC;
              silence = 0;
              onsets++;
              for (i = 0; i < preroll_len && phase == PH_REC; i++)
                store_sample(preroll_mem[i]);
            end
          end else if (phase == PH_REC) begin
            if (r.vad_speech) begin
              silence = 0;
            end else begin
              if (silence > SIL_CEIL - SILENCE_STEP) silence = SIL_CEIL;
              else silence += SILENCE_STEP;
              if (silence >= sil_reg) phase = PH_DONE;
            end
          end else begin
            live = 1'b0;
          end
        end
        default: begin
          if (phase != PH_DONE) begin
            want.status = STS_NOT_DONE;
          end else if (r.read_index >= fill) begin
            want.status = STS_RANGE;
          end else begin
            want.read_sample = capture_mem[r.read_index];
            reads_with_data++;
          end
        end
      endcase
      if (phase == PH_DONE && was != PH_DONE) completions++;
      want.phase          = phase;
      want.captured_count = fill[COUNT_W-1:0];
      awaited.push_back(want);
      return live;
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        $error("result with no item outstanding: status %0d phase %0d count %0d",
               got.status, got.phase, got.captured_count);
        failures++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        failures++;
      end
      if (got.captured_count !== want.captured_count) begin
        $error("captured_count: expected %0d, got %0d",
               want.captured_count, got.captured_count);
        failures++;
      end
      if (got.read_sample !== want.read_sample) begin
        $error("read_sample: expected %0d, got %0d",
               $signed(want.read_sample), $signed(got.read_sample));
        failures++;
      end
    endfunction
  endclass

endpackage

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for vad_gated_audio_capture
// Drives start, sample, VAD and read items through the request channel with
// random gaps, stalls the result channel at random, and checks every result
// against an in-bench predictor. Register settings change between phases,
// from the extremes to small capture lengths that complete often.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import vgac_pkg::*;
  import vgac_tb_pkg::*;

  // hang guard; the slowest legal run is far below this
  localparam int unsigned RUN_LIMIT   = 3_000_000;
  // cycles left after the last result before the registers are touched
  localparam int          SETTLE      = 4;
  localparam int unsigned RANDOM_LIVE = 750;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  vgac_req_if req_ch ();
  vgac_rsp_if rsp_ch ();

  capture_checker chk;
  bit             calm;          // no gaps and no stalls while set
  bit             tally;         // count live items of the random part
  int unsigned    random_items;
  int unsigned    cycles;
  int             stall_left = 0;

  vad_gated_audio_capture #(
    .CAPTURE_DEPTH (CAP_DEPTH),
    .PREROLL_DEPTH (PREROLL_DEPTH),
    .SILENCE_STEP  (SILENCE_STEP)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly back to back, often a short gap, now and then a long one.
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Every field random, so that fields the operation ignores still toggle.
  function automatic req_t any_item(op_t op);
    req_t r;
    r.operation    = op;
    r.sample_value = 16'($urandom);
    r.chunk_first  = 1'($urandom);
    r.vad_speech   = 1'($urandom);
    r.read_index   = 17'($urandom);
    return r;
  endfunction

  function automatic logic [MAX_CAP_W-1:0] pick_max();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 18'($urandom_range(1, 24));
    if (p < 75) return 18'($urandom_range(25, 300));
    if (p < 83) return 18'd0;
    if (p < 90) return MAX_CAP_RESET;
    if (p < 95) return 18'($urandom_range(131073, 262143));
    return 18'h3FFFF;
  endfunction

  function automatic logic [SIL_W-1:0] pick_sil();
    int p;
    p = $urandom_range(0, 99);
    if (p < 35) return 21'(SILENCE_STEP * $urandom_range(1, 8));
    if (p < 55) return 21'($urandom_range(1, 6000));
    if (p < 63) return 21'd0;
    if (p < 70) return 21'd1;
    if (p < 78) return 21'd1048576;
    if (p < 85) return SIL_MAX;
    return 21'($urandom);
  endfunction

  // Present one item and hold it until taken. valid is only lowered when a
  // gap follows, so it never gets two assignments in one step.
  task automatic send(req_t r);
    int gap;
    gap = calm ? 0 : idle_len();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= r;
    do @(posedge clk); while (!req_ch.ready);
    if (chk.accept_request(r) && tally) random_items++;
  endtask

  task automatic start_capture();
    send(any_item(OP_START));
  endtask

  task automatic feed(logic [SAMPLE_W-1:0] v, bit first);
    req_t r;
    r = any_item(OP_SAMPLE);
    r.sample_value = v;
    r.chunk_first  = first;
    send(r);
  endtask

  task automatic vad(bit speech);
    req_t r;
    r = any_item(OP_VAD);
    r.vad_speech = speech;
    send(r);
  endtask

  task automatic read_at(logic [READ_INDEX_W-1:0] idx);
    req_t r;
    r = any_item(OP_READ);
    r.read_index = idx;
    send(r);
  endtask

  // Stop offering items and wait until every result is in. The queue is
  // polled on the falling edge so the outcome never hinges on process order.
  task automatic drain();
    req_ch.valid <= 1'b0;
    while (chk.awaited.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Both registers in turn; the length word carries random bits above
  // the register width, which the block must drop.
  task automatic configure(logic [MAX_CAP_W-1:0] max_len, logic [SIL_W-1:0] sil_lim);
    logic [CFG_DATA_W-1:0] word;
    word = {3'($urandom), max_len};
    cfg_we    <= 1'b1;
    cfg_index <= CFG_MAX_CAPTURE;
    cfg_data  <= word;
    @(posedge clk);
    chk.write_reg(CFG_MAX_CAPTURE, word);
    cfg_index <= CFG_SILENCE_LIMIT;
    cfg_data  <= sil_lim;
    @(posedge clk);
    chk.write_reg(CFG_SILENCE_LIMIT, sil_lim);
    cfg_we <= 1'b0;
  endtask

  // Reads after a session: mostly inside the capture, some at or past its end.
  task automatic read_back_some();
    int          n;
    int unsigned idx;
    n = $urandom_range(1, 6);
    repeat (n) begin
      if (chk.fill > 0 && $urandom_range(0, 3) != 0) idx = $urandom_range(0, chk.fill - 1);
      else if ($urandom_range(0, 1) == 1) idx = chk.fill;
      else idx = $urandom;
      read_at(17'(idx));
    end
  endtask

  // Result side: check every item taken, then choose next cycle's ready.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) chk.check_result(rsp_ch.data);
    if (stall_left > 0) begin
      rsp_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rsp_ch.ready <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 30) stall_left = idle_len();
    end
  end

  initial begin
    cycles = 0;
    while (cycles < RUN_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout: run still busy after %0d cycles", RUN_LIMIT);
    $display("vad_gated_audio_capture verification failed");
    $finish;
  end

  initial begin
    int session;
    int len;
    int budget;
    int retune_at;
    int steps;
    int p;
    int j;
    bit first;

    chk          = new();
    calm         = 1'b0;
    tally        = 1'b0;
    random_items = 0;
    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= CFG_MAX_CAPTURE;
    cfg_data     <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part, registers at their reset values ----
    // idle: read refused, sample and frame dropped
    read_at(17'd0);
    feed(16'h7FFF, 1'b1);
    vad(1'b1);
    start_capture();
    read_at(17'h1FFFF);            // read while waiting is refused
    feed(16'h8000, 1'b1);
    feed(16'h7FFF, 1'b0);
    feed(16'hFFFF, 1'b0);
    vad(1'b0);                     // silence while waiting changes nothing
    feed(16'h0001, 1'b1);          // new chunk throws the older pre-roll away
    feed(16'h5555, 1'b0);
    vad(1'b1);                     // onset copies the two pre-roll samples
    feed(16'hAAAA, 1'b0);
    feed(16'h0000, 1'b1);          // chunk mark means nothing while recording
    vad(1'b0);
    vad(1'b1);
    // length register of zero acts as one, well under the fill of four
    drain();
    configure(18'd0, 21'd0);
    feed(16'h1234, 1'b0);          // dropped, capture completes
    read_at(17'd3);
    read_at(17'd0);
    read_at(17'd4);                // one past the end
    start_capture();               // restart from complete
    feed(16'h4321, 1'b1);
    feed(16'hBEEF, 1'b0);
    vad(1'b1);                     // pre-roll bigger than the room: one fits
    read_at(17'd0);
    start_capture();
    vad(1'b1);                     // empty pre-roll
    vad(1'b0);                     // zero silence limit: first silent frame ends it
    read_at(17'd0);

    // ---- random sessions ----
    tally   = 1'b1;
    session = 0;
    while (random_items < RANDOM_LIVE) begin
      session++;
      drain();
      calm = ($urandom_range(0, 3) == 0);

      if (session == 3) begin
        // one chunk longer than the pre-roll store, then a full-size copy
        tally = 1'b0;
        configure(MAX_CAP_RESET, SIL_LIMIT_RESET);
        start_capture();
        len = $urandom_range(PREROLL_DEPTH + 1, PREROLL_DEPTH + 40);
        for (j = 0; j < len; j++) feed(16'($urandom), j == 0);
        vad(1'b1);
        repeat ($urandom_range(1, 5)) feed(16'($urandom), 1'($urandom));
        while (chk.phase == PH_REC) vad(1'b0);
        read_at(17'd0);
        read_at(17'(PREROLL_DEPTH - 1));
        read_at(17'(PREROLL_DEPTH));
        read_at(17'(chk.fill));
        read_back_some();
        tally = 1'b1;
      end else if (session == 6) begin
        // silence total runs into its ceiling against the largest limit
        tally = 1'b0;
        configure(MAX_CAP_RESET, SIL_MAX);
        start_capture();
        feed(16'($urandom), 1'b1);
        vad(1'b1);
        while (chk.phase == PH_REC) vad(1'b0);
        read_back_some();
        tally = 1'b1;
      end else if ($urandom_range(0, 6) == 0) begin
        // noise: any operation with any content
        configure(pick_max(), pick_sil());
        repeat ($urandom_range(10, 40)) send(any_item(op_t'(2'($urandom))));
        read_back_some();
      end else begin
        // well-formed: start, a few chunks, usually an onset, record to the end or the step budget
        configure(pick_max(), pick_sil());
        start_capture();
        repeat ($urandom_range(0, 3)) begin
          len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
          for (j = 0; j < len; j++) begin
            first = (j == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 29) == 0);
            feed(16'($urandom), first);
            if ($urandom_range(0, 9) == 0) vad(1'b0);
          end
        end
        if ($urandom_range(0, 9) != 0) vad(1'b1);
        budget    = $urandom_range(10, 150);
        retune_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, budget) : -1;
        for (steps = 0; steps < budget && chk.phase == PH_REC; steps++) begin
          // mid-recording length change, at times below the current fill
          if (steps == retune_at) begin
            drain();
            configure(18'($urandom_range(0, chk.fill + 2)), chk.sil_reg);
          end
          p = $urandom_range(0, 99);
          if (p < 65) feed(16'($urandom), $urandom_range(0, 9) == 0);
          else if (p < 75) vad(1'b1);
          else if (p < 97) vad(1'b0);
          else read_at(17'($urandom));
        end
        read_back_some();
      end
    end

    // ---- wind down ----
    drain();
    repeat (16) @(posedge clk);
    if (chk.awaited.size() != 0)
      $error("%0d expected results never arrived", chk.awaited.size());
    $display("covered %0d starts, %0d samples, %0d VAD frames, %0d reads (%0d with data)",
             chk.op_seen[OP_START], chk.op_seen[OP_SAMPLE], chk.op_seen[OP_VAD],
             chk.op_seen[OP_READ], chk.reads_with_data);
    $display("%0d speech onsets, %0d captures completed, %0d results checked, %0d cycles",
             chk.onsets, chk.completions, chk.checked, cycles);
    if (chk.failures == 0 && chk.awaited.size() == 0) begin
      $display("vad_gated_audio_capture verification clean");
    end else begin
      $display("vad_gated_audio_capture verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/vgac_pkg.sv
src/vgac_if.sv
src/vgac_ram.sv
src/vad_gated_audio_capture.sv
sim/vgac_tb_pkg.sv
sim/tb_top.sv
